// ----- rtl/pai_pkg.sv -----
package pai_pkg;

  localparam int PHASE_COUNT    = 256;
  localparam int SHORT_TAPS     = 4;
  localparam int LONG_TAPS      = 8;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 15;

  localparam int COEF_W  = COEF_FRAC_BITS + 1;
  localparam int PHASE_W = 8;
  localparam int ROW_W   = $clog2(PHASE_COUNT);
  localparam int PROD_W  = SAMPLE_BITS + COEF_W;
  localparam int PAIR_W  = PROD_W + 1;
  localparam int ACC_W   = PROD_W + $clog2(LONG_TAPS);
  localparam int PAIRS   = LONG_TAPS / 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [PAIR_W-1:0]      pair_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [PHASE_W-1:0]            phase_t;
  typedef logic [ROW_W-1:0]              row_t;

  typedef struct packed {
    sample_t [LONG_TAPS-1:0] smp;
    coef_t   [LONG_TAPS-1:0] coef;
  } tap_set_t;

  typedef logic [PHASE_COUNT-1:0][SHORT_TAPS-1:0][COEF_W-1:0] gauss_rom_t;
  typedef logic [PHASE_COUNT-1:0][LONG_TAPS-1:0][COEF_W-1:0]  sinc_rom_t;

  // Fixed-point helpers for building the coefficient tables at elaboration.
  // All intermediate values are Q34.30 (30 fraction bits) held in 64-bit integers.
  localparam int              QB        = 30;
  localparam longint          QONE      = longint'(1) << QB;
  localparam longint unsigned QHALF     = 64'd1 << (QB - 1);
  localparam longint          PI_Q      = 64'sd3373259426;
  localparam longint          SIGMA_NUM = 45;
  localparam longint          SIGMA_DEN = 100;
  localparam longint          FC_NUM    = 19;
  localparam longint          FC_DEN    = 40;

  function automatic longint unsigned mag(input longint a);
    return (a < 0) ? (64'd0 - $unsigned(a)) : $unsigned(a);
  endfunction

  function automatic longint apply_sign(input longint unsigned m, input logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // Restoring shift-subtract division, one quotient bit per step.
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    logic [64:0]     rem;
    longint unsigned q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint unsigned p;
    p = (mag(a) * mag(b) + QHALF) >> QB;
    return apply_sign(p, (a < 0) != (b < 0));
  endfunction

  // Rounded a * 2^sh / b with ties away from zero; zero when b is zero.
  function automatic longint qdiv(input longint a, input longint b, input int sh);
    longint unsigned ub;
    longint unsigned q;
    ub = mag(b);
    if (ub == 64'd0) begin
      return 0;
    end
    q = udiv((mag(a) << sh) + (ub >> 1), ub);
    return apply_sign(q, (a < 0) != (b < 0));
  endfunction

  function automatic longint exp_neg_small(input longint r);
    longint sum;
    longint term;
    sum  = QONE;
    term = QONE;
    for (int k = 1; k <= 20; k++) begin
      term = $signed(udiv($unsigned(qmul(term, r)), 64'(k)));
      sum  = sum + (((k % 2) == 1) ? -term : term);
    end
    return sum;
  endfunction

  function automatic longint exp_neg(input longint y, input longint e1);
    longint unsigned n;
    longint          e;
    n = $unsigned(y) >> QB;
    e = exp_neg_small($signed($unsigned(y) & $unsigned(QONE - 1)));
    if (n > 64'd64) begin
      return 0;
    end
    for (int i = 0; i < 64; i++) begin
      if (64'(i) < n) begin
        e = qmul(e, e1);
      end
    end
    return e;
  endfunction

  function automatic longint sin_series(input longint th);
    longint t2;
    longint sum;
    longint term;
    t2   = qmul(th, th);
    sum  = th;
    term = th;
    for (int n = 1; n <= 12; n++) begin
      term = $signed(udiv($unsigned(qmul(term, t2)), 64'((2 * n) * (2 * n + 1))));
      sum  = sum + (((n % 2) == 1) ? -term : term);
    end
    return sum;
  endfunction

  function automatic longint cos_series(input longint th);
    longint t2;
    longint sum;
    longint term;
    t2   = qmul(th, th);
    sum  = QONE;
    term = QONE;
    for (int n = 1; n <= 12; n++) begin
      term = $signed(udiv($unsigned(qmul(term, t2)), 64'((2 * n - 1) * (2 * n))));
      sum  = sum + (((n % 2) == 1) ? -term : term);
    end
    return sum;
  endfunction

  // Sine of an angle in turns: reduce to one turn, then one quadrant.
  function automatic longint sin_turns(input longint t);
    longint unsigned u;
    logic [1:0]      quad;
    longint          r;
    longint          th;
    longint          res;
    u    = $unsigned(t) & $unsigned(QONE - 1);
    quad = u[QB-1 -: 2];
    r    = $signed(u & ((64'd1 << (QB - 2)) - 64'd1));
    th   = qmul(r, 2 * PI_Q);
    case (quad)
      2'd0:    res = sin_series(th);
      2'd1:    res = cos_series(th);
      2'd2:    res = -sin_series(th);
      default: res = -cos_series(th);
    endcase
    return res;
  endfunction

  function automatic logic [COEF_W-1:0] norm_coef(input longint c, input longint sum);
    longint v;
    longint hi;
    longint lo;
    v  = qdiv(c, sum, COEF_FRAC_BITS);
    hi = (longint'(1) << COEF_FRAC_BITS) - 1;
    lo = -(longint'(1) << COEF_FRAC_BITS);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[COEF_W-1:0];
  endfunction

  function automatic gauss_rom_t build_gauss_rom();
    gauss_rom_t rom;
    longint     f;
    longint     rel;
    longint     r2;
    longint     y;
    longint     e1;
    longint     sum;
    longint     cg [SHORT_TAPS];
    e1 = exp_neg_small(QONE);
    for (int p = 0; p < PHASE_COUNT; p++) begin
      f   = (longint'(p) << QB) / PHASE_COUNT;
      sum = 0;
      for (int k = 0; k < SHORT_TAPS; k++) begin
        rel   = f + 3 * QONE / 2 - longint'(k) * QONE;
        r2    = qmul(rel, rel);
        y     = r2 * (SIGMA_DEN * SIGMA_DEN) / (2 * SIGMA_NUM * SIGMA_NUM);
        cg[k] = exp_neg(y, e1);
        sum   = sum + cg[k];
      end
      for (int k = 0; k < SHORT_TAPS; k++) begin
        rom[p][k] = (sum == 0) ? '0 : norm_coef(cg[k], sum);
      end
    end
    return rom;
  endfunction

  function automatic sinc_rom_t build_sinc_rom();
    sinc_rom_t rom;
    longint    f;
    longint    x;
    longint    w;
    longint    h;
    longint    sum;
    longint    cs [LONG_TAPS];
    for (int p = 0; p < PHASE_COUNT; p++) begin
      f   = (longint'(p) << QB) / PHASE_COUNT;
      sum = 0;
      for (int k = 0; k < LONG_TAPS; k++) begin
        x = longint'(k - 3) * QONE - f;
        w = QONE / 2 + qmul(QONE / 2, sin_turns(x / 8 + QONE / 4));
        if (x == 0) begin
          h = QONE * 2 * FC_NUM / FC_DEN;
        end else begin
          h = qdiv(sin_turns(x * FC_NUM / FC_DEN), qmul(PI_Q, x), QB);
        end
        cs[k] = qmul(w, h);
        sum   = sum + cs[k];
      end
      for (int k = 0; k < LONG_TAPS; k++) begin
        rom[p][k] = (sum == 0) ? '0 : norm_coef(cs[k], sum);
      end
    end
    return rom;
  endfunction

  localparam gauss_rom_t GAUSS_ROM = build_gauss_rom();
  localparam sinc_rom_t  SINC_ROM  = build_sinc_rom();

endpackage

// ----- rtl/pai_coef_fetch.sv -----
module pai_coef_fetch (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  pai_pkg::sample_t [pai_pkg::LONG_TAPS-1:0] in_smp,
  input  pai_pkg::phase_t                           in_phase,
  input  logic                                      kernel_mode,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output pai_pkg::tap_set_t                         out_taps
);
  import pai_pkg::*;

  localparam int PROD_ROW_W = PHASE_W + ROW_W + 1;

  logic                   valid_r;
  tap_set_t               taps_r;
  tap_set_t               taps_nxt;
  logic [PROD_ROW_W-1:0]  row_prod;
  row_t                   row;

  // Row = phase * PHASE_COUNT / 256, always below PHASE_COUNT.
  assign row_prod = PROD_ROW_W'(in_phase) * PROD_ROW_W'(PHASE_COUNT);
  assign row      = row_prod[PHASE_W +: ROW_W];

  always_comb begin
    taps_nxt.smp = in_smp;
    for (int k = 0; k < LONG_TAPS; k++) begin
      if (kernel_mode) begin
        taps_nxt.coef[k] = SINC_ROM[row][k];
      end else if (k < SHORT_TAPS) begin
        taps_nxt.coef[k] = GAUSS_ROM[row][k];
      end else begin
        taps_nxt.coef[k] = '0;
      end
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      taps_r <= taps_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_taps  = taps_r;

endmodule

// ----- rtl/pai_mac.sv -----
module pai_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pai_pkg::tap_set_t in_taps,
  output logic              out_valid,
  input  logic              out_ready,
  output pai_pkg::acc_t     out_acc
);
  import pai_pkg::*;

  // Three stages: products, pair sums, final sum.
  logic  mul_valid_r;
  logic  pair_valid_r;
  logic  sum_valid_r;
  logic  mul_ready;
  logic  pair_ready;
  logic  sum_ready;

  prod_t [LONG_TAPS-1:0] prod_r;
  prod_t [LONG_TAPS-1:0] prod_nxt;
  pair_t [PAIRS-1:0]     pair_r;
  pair_t [PAIRS-1:0]     pair_nxt;
  acc_t                  acc_r;
  acc_t                  acc_nxt;

  assign sum_ready  = !sum_valid_r || out_ready;
  assign pair_ready = !pair_valid_r || sum_ready;
  assign mul_ready  = !mul_valid_r || pair_ready;
  assign in_ready   = mul_ready;

  always_comb begin
    for (int k = 0; k < LONG_TAPS; k++) begin
      prod_nxt[k] = PROD_W'($signed(in_taps.smp[k]) * $signed(in_taps.coef[k]));
    end
  end

  always_comb begin
    for (int j = 0; j < PAIRS; j++) begin
      pair_nxt[j] = PAIR_W'($signed(prod_r[2*j])) + PAIR_W'($signed(prod_r[2*j+1]));
    end
  end

  always_comb begin
    acc_nxt = '0;
    for (int j = 0; j < PAIRS; j++) begin
      acc_nxt = acc_nxt + ACC_W'($signed(pair_r[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r  <= 1'b0;
      pair_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_valid_r <= in_valid;
      end
      if (pair_ready) begin
        pair_valid_r <= mul_valid_r;
      end
      if (sum_ready) begin
        sum_valid_r <= pair_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && in_valid) begin
      prod_r <= prod_nxt;
    end
    if (pair_ready && mul_valid_r) begin
      pair_r <= pair_nxt;
    end
    if (sum_ready && pair_valid_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign out_valid = sum_valid_r;
  assign out_acc   = acc_r;

endmodule

// ----- rtl/pai_round_sat.sv -----
module pai_round_sat (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pai_pkg::acc_t    in_acc,
  output logic             out_valid,
  input  logic             out_stall,
  output pai_pkg::sample_t out_result_sample,
  output logic             out_clipped
);
  import pai_pkg::*;

  localparam int QW = ACC_W + 1 - COEF_FRAC_BITS;

  localparam logic signed [ACC_W:0] ROUND_BIAS =
    {{(ACC_W - COEF_FRAC_BITS + 1){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
  localparam logic signed [QW-1:0] SAT_HI =
    {{(QW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [QW-1:0] SAT_LO =
    {{(QW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  logic                valid_r;
  sample_t             result_r;
  sample_t             result_nxt;
  logic                clip_r;
  logic                clip_nxt;
  logic signed [ACC_W:0] biased;
  logic signed [QW-1:0]  q;

  // Adding half an LSB and dropping the fraction bits with an arithmetic
  // shift rounds to nearest with ties toward positive infinity.
  assign biased = (ACC_W + 1)'(in_acc) + ROUND_BIAS;
  assign q      = $signed(biased[ACC_W:COEF_FRAC_BITS]);

  always_comb begin
    if (q > SAT_HI) begin
      result_nxt = SAT_HI[SAMPLE_BITS-1:0];
      clip_nxt   = 1'b1;
    end else if (q < SAT_LO) begin
      result_nxt = SAT_LO[SAMPLE_BITS-1:0];
      clip_nxt   = 1'b1;
    end else begin
      result_nxt = q[SAMPLE_BITS-1:0];
      clip_nxt   = 1'b0;
    end
  end

  assign in_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result_r <= result_nxt;
      clip_r   <= clip_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_result_sample = result_r;
  assign out_clipped       = clip_r;

endmodule

// ----- rtl/polyphase_audio_interpolator.sv -----
// Channel   Direction  Handshake          Word
// in_       input      valid / stall      eight samples and an 8-bit phase
// out_      output     valid / stall      result sample and clip flag
// cfg_      input      valid / ready      kernel_mode (1 bit)
//
// One word per clock while in_stall is low; a result passes through five register
// stages in order: coefficient lookup, multiply, pair add, final add, and
// round with saturation.
// Synchronous active-low reset clears the valid bits and selects the Gaussian
// kernel; the coefficient tables are constants, so no clearing pass is needed.
// Each stage holds while the one after it is full, so out_stall backs up only
// as far as the pipeline is occupied and no word is lost or repeated.
module polyphase_audio_interpolator (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pai_pkg::sample_t in_sample0,
  input  pai_pkg::sample_t in_sample1,
  input  pai_pkg::sample_t in_sample2,
  input  pai_pkg::sample_t in_sample3,
  input  pai_pkg::sample_t in_sample4,
  input  pai_pkg::sample_t in_sample5,
  input  pai_pkg::sample_t in_sample6,
  input  pai_pkg::sample_t in_sample7,
  input  pai_pkg::phase_t  in_phase,
  output logic             out_valid,
  input  logic             out_stall,
  output pai_pkg::sample_t out_result_sample,
  output logic             out_clipped,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_kernel_mode
);
  import pai_pkg::*;

  logic                    kernel_mode_r;
  sample_t [LONG_TAPS-1:0] in_smp;
  logic                    fetch_in_ready;
  logic                    fetch_valid;
  tap_set_t                fetch_taps;
  logic                    mac_in_ready;
  logic                    mac_valid;
  acc_t                    mac_acc;
  logic                    rs_in_ready;

  assign in_smp = {in_sample7, in_sample6, in_sample5, in_sample4,
                   in_sample3, in_sample2, in_sample1, in_sample0};

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      kernel_mode_r <= cfg_kernel_mode;
    end
  end

  pai_coef_fetch u_fetch (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (fetch_in_ready),
    .in_smp      (in_smp),
    .in_phase    (in_phase),
    .kernel_mode (kernel_mode_r),
    .out_valid   (fetch_valid),
    .out_ready   (mac_in_ready),
    .out_taps    (fetch_taps)
  );

  pai_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fetch_valid),
    .in_ready  (mac_in_ready),
    .in_taps   (fetch_taps),
    .out_valid (mac_valid),
    .out_ready (rs_in_ready),
    .out_acc   (mac_acc)
  );

  pai_round_sat u_round_sat (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (mac_valid),
    .in_ready          (rs_in_ready),
    .in_acc            (mac_acc),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_sample (out_result_sample),
    .out_clipped       (out_clipped)
  );

  assign in_stall = !fetch_in_ready;

`ifndef SYNTHESIS
  // The input can only be held off when every stage downstream is occupied.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (fetch_valid && mac_valid && out_valid && out_stall))
    else $error("input stalled while the pipeline has a free stage");

  a_accept_fills_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> fetch_valid)
    else $error("accepted word did not reach the fetch stage");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_result_sample == 16'sh7fff || out_result_sample == 16'sh8000))
    else $error("clip flag set on a result that is not at a limit");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (kernel_mode_r == $past(cfg_kernel_mode)))
    else $error("kernel mode write was not taken");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
